// ----- src/ratpp_pkg.sv -----
`default_nettype none

package ratpp_pkg;

  localparam int unsigned WindowLenDefault = 10;

  localparam int RssiW    = 8;
  localparam int LatencyW = 10;
  localparam int LimitW   = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  typedef enum logic [1:0] {
    LINK_STA_UP   = 2'd0,
    LINK_STA_DOWN = 2'd1,
    LINK_AP       = 2'd2,
    LINK_OTHER    = 2'd3
  } link_mode_e;

  typedef enum logic [1:0] {
    PWR_8P5  = 2'd0,
    PWR_13   = 2'd1,
    PWR_17   = 2'd2,
    PWR_19P5 = 2'd3
  } power_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIGH_THR     = 3'd0,
    CFG_LOW_THR      = 3'd1,
    CFG_MID_FLOOR    = 3'd2,
    CFG_WEAK_LIMIT   = 3'd3,
    CFG_LATENCY_LIM  = 3'd4,
    CFG_PING_FAIL    = 3'd5,
    CFG_DISCONNECT   = 3'd6
  } cfg_idx_e;

  localparam logic signed [RssiW-1:0] HighThrReset   = -8'sd45;
  localparam logic signed [RssiW-1:0] LowThrReset    = -8'sd55;
  localparam logic signed [RssiW-1:0] MidFloorReset  = -8'sd72;
  localparam logic signed [RssiW-1:0] WeakLimitReset = -8'sd78;
  localparam logic [LatencyW-1:0]     LatencyReset   = 10'd150;
  localparam logic [LimitW-1:0]       PingFailReset  = 4'd3;
  localparam logic [LimitW-1:0]       DisconnReset   = 4'd3;
  localparam logic signed [RssiW-1:0] WindowFill     = -8'sd70;
  localparam logic [LimitW-1:0]       CountMax       = 4'd15;

  typedef struct packed {
    logic signed [RssiW-1:0] high_thr;
    logic signed [RssiW-1:0] low_thr;
    logic signed [RssiW-1:0] mid_floor;
    logic signed [RssiW-1:0] weak_limit;
    logic [LatencyW-1:0]     latency_limit;
    logic [LimitW-1:0]       ping_fail_limit;
    logic [LimitW-1:0]       disconnect_limit;
  } cfg_t;

  typedef struct packed {
    logic                    action;
    link_mode_e              link_mode;
    logic signed [RssiW-1:0] rssi;
    logic                    ping_ok;
    logic [LatencyW-1:0]     latency;
    logic                    scan_not_ready;
  } item_t;

  typedef struct packed {
    logic   power_write;
    power_e power_code;
    logic   restart_link;
    logic   request_scan;
  } result_t;

endpackage

`default_nettype wire

// ----- src/ratpp_window.sv -----
`default_nettype none

module ratpp_window #(
  parameter int unsigned WINDOW_LEN = ratpp_pkg::WindowLenDefault,
  localparam int SumW = $clog2(WINDOW_LEN * 128) + 1
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 step_i,
  input  wire logic                                 prime_i,
  input  wire logic                                 push_i,
  input  wire logic signed [ratpp_pkg::RssiW-1:0]   rssi_i,
  output logic signed [SumW-1:0]                    sum_o
);

  localparam int PtrW = $clog2(WINDOW_LEN);
  localparam logic signed [SumW-1:0] LenS = SumW'(WINDOW_LEN);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(WINDOW_LEN - 1);

  logic signed [ratpp_pkg::RssiW-1:0] win_q [WINDOW_LEN];
  logic [PtrW-1:0]                    ptr_q, ptr_d;
  logic signed [SumW-1:0]             sum_q, sum_d;
  logic signed [SumW-1:0]             rssi_ext;
  logic signed [SumW-1:0]             old_ext;

  assign rssi_ext = SumW'(rssi_i);
  assign old_ext  = SumW'(win_q[ptr_q]);

  always_comb begin
    sum_d = sum_q;
    ptr_d = ptr_q;
    if (prime_i) begin
      sum_d = rssi_ext * LenS;
      ptr_d = '0;
    end else if (push_i) begin
      sum_d = sum_q - old_ext + rssi_ext;
      ptr_d = (ptr_q == PtrLast) ? '0 : ptr_q + PtrW'(1);
    end
  end

  assign sum_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      sum_q <= SumW'(ratpp_pkg::WindowFill) * LenS;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= ratpp_pkg::WindowFill;
      end
    end else if (step_i) begin
      ptr_q <= ptr_d;
      sum_q <= sum_d;
      if (prime_i) begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
          win_q[i] <= rssi_i;
        end
      end else if (push_i) begin
        win_q[ptr_q] <= rssi_i;
      end
    end
  end

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ptr_q} < (PtrW+1)'(WINDOW_LEN))
    else $error("window pointer out of range");

  a_prime_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && prime_i |=> ptr_q == '0)
    else $error("prime did not rewind the window");

endmodule

`default_nettype wire

// ----- src/ratpp_policy.sv -----
`default_nettype none

module ratpp_policy #(
  parameter int unsigned WINDOW_LEN = ratpp_pkg::WindowLenDefault,
  localparam int SumW = $clog2(WINDOW_LEN * 128) + 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire ratpp_pkg::item_t        item_i,
  input  wire ratpp_pkg::cfg_t         cfg_i,
  input  wire logic signed [SumW-1:0]  sum_i,
  output ratpp_pkg::result_t           result_o
);

  localparam logic signed [SumW-1:0] LenS = SumW'(WINDOW_LEN);

  logic [ratpp_pkg::LimitW-1:0] fail_q, fail_d, fail_inc;
  logic [ratpp_pkg::LimitW-1:0] disc_q, disc_d, disc_inc;
  ratpp_pkg::power_e            track_q, track_d, choice;
  logic signed [SumW-1:0]       hi_s, lo_s, floor_s, weak_s;
  logic                         weak_hit;

  assign hi_s     = SumW'(cfg_i.high_thr) * LenS;
  assign lo_s     = SumW'(cfg_i.low_thr) * LenS;
  assign floor_s  = SumW'(cfg_i.mid_floor) * LenS;
  assign weak_s   = SumW'(cfg_i.weak_limit) * LenS;
  assign weak_hit = sum_i < weak_s;

  always_comb begin
    fail_d   = fail_q;
    disc_d   = disc_q;
    track_d  = track_q;
    result_o = '{power_write: 1'b0, power_code: ratpp_pkg::PWR_8P5,
                 restart_link: 1'b0, request_scan: 1'b0};
    fail_inc = (fail_q < cfg_i.ping_fail_limit) ? fail_q + 4'd1 : fail_q;
    disc_inc = (disc_q < ratpp_pkg::CountMax) ? disc_q + 4'd1 : disc_q;
    choice   = track_q;
    if (sum_i > hi_s) begin
      choice = ratpp_pkg::PWR_8P5;
    end else if (sum_i < lo_s && sum_i > floor_s) begin
      choice = ratpp_pkg::PWR_13;
    end
    if (item_i.action) begin
      fail_d = '0;
      disc_d = '0;
    end else begin
      unique case (item_i.link_mode)
        ratpp_pkg::LINK_STA_UP: begin
          if (weak_hit) begin
            fail_d = item_i.ping_ok ? '0 : fail_inc;
            if (fail_d >= cfg_i.ping_fail_limit) begin
              result_o.power_write = 1'b1;
              result_o.power_code  = ratpp_pkg::PWR_19P5;
            end else if (item_i.latency > cfg_i.latency_limit) begin
              result_o.power_write = 1'b1;
              result_o.power_code  = ratpp_pkg::PWR_17;
            end
          end else if (choice != track_q) begin
            track_d              = choice;
            result_o.power_write = 1'b1;
            result_o.power_code  = choice;
          end
        end
        ratpp_pkg::LINK_STA_DOWN: begin
          disc_d = disc_inc;
          if (disc_inc >= cfg_i.disconnect_limit) begin
            disc_d                = '0;
            result_o.restart_link = 1'b1;
          end
        end
        ratpp_pkg::LINK_AP: begin
          fail_d                = '0;
          disc_d                = '0;
          result_o.power_write  = 1'b1;
          result_o.power_code   = ratpp_pkg::PWR_19P5;
          result_o.request_scan = item_i.scan_not_ready;
        end
        ratpp_pkg::LINK_OTHER: begin
          fail_d = '0;
          disc_d = '0;
        end
        default: begin
          fail_d = '0;
          disc_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q  <= '0;
      disc_q  <= '0;
      track_q <= ratpp_pkg::PWR_19P5;
    end else if (step_i) begin
      fail_q  <= fail_d;
      disc_q  <= disc_d;
      track_q <= track_d;
    end
  end

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.restart_link |=> disc_q == '0)
    else $error("restart left the disconnect count set");

  a_restart_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.restart_link |-> !result_o.power_write && !result_o.request_scan)
    else $error("restart mixed with another request");

endmodule

`default_nettype wire

// ----- src/rssi_averaged_tx_power_policy.sv -----
// Transmit power policy driven by a running RSSI average.
// Input channel: in_valid_i / in_stall_o with one port per item field.
// A prime item (action_i high) fills the averaging window with its sample
// and clears the counters; a tick item acts according to link_mode_i.
// Output channel: out_valid_o / out_stall_i; exactly one result item per
// input item, carrying power_write_o, power_code_o, restart_link_o and
// request_scan_o.
// Each accepted item waits in the input register; its result is loaded into
// the result register when the item advances.
// Throughput is one item per cycle while the receiver does not stall; the
// window keeps a running sum so a push step is a single add and subtract.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i;
// write only while no item is in flight.
// Reset clears the window to -70 dBm per entry, both counters, and sets the
// tracked power to 19.5 dBm; no items are held.
// When the receiver stalls, the result register holds; an empty input register
// still takes one more item, and then in_stall_o is raised.
`default_nettype none

module rssi_averaged_tx_power_policy #(
  parameter int unsigned WINDOW_LEN = ratpp_pkg::WindowLenDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ratpp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [ratpp_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  action_i,
  input  wire logic [1:0]                            link_mode_i,
  input  wire logic signed [ratpp_pkg::RssiW-1:0]    rssi_dbm_i,
  input  wire logic                                  ping_ok_i,
  input  wire logic [ratpp_pkg::LatencyW-1:0]        ping_latency_ms_i,
  input  wire logic                                  scan_not_ready_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic                                       power_write_o,
  output logic [1:0]                                 power_code_o,
  output logic                                       restart_link_o,
  output logic                                       request_scan_o
);

  localparam int SumW = $clog2(WINDOW_LEN * 128) + 1;

  ratpp_pkg::cfg_t    cfg_q;
  ratpp_pkg::item_t   item_q;
  ratpp_pkg::result_t res_q, res_d;
  logic               in_valid_q, in_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               advance, accept;
  logic signed [SumW-1:0] sum;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = (in_valid_q && !advance) || accept;
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr         <= ratpp_pkg::HighThrReset;
      cfg_q.low_thr          <= ratpp_pkg::LowThrReset;
      cfg_q.mid_floor        <= ratpp_pkg::MidFloorReset;
      cfg_q.weak_limit       <= ratpp_pkg::WeakLimitReset;
      cfg_q.latency_limit    <= ratpp_pkg::LatencyReset;
      cfg_q.ping_fail_limit  <= ratpp_pkg::PingFailReset;
      cfg_q.disconnect_limit <= ratpp_pkg::DisconnReset;
    end else if (cfg_we_i) begin
      unique case (ratpp_pkg::cfg_idx_e'(cfg_index_i))
        ratpp_pkg::CFG_HIGH_THR:    cfg_q.high_thr   <= cfg_wdata_i[ratpp_pkg::RssiW-1:0];
        ratpp_pkg::CFG_LOW_THR:     cfg_q.low_thr    <= cfg_wdata_i[ratpp_pkg::RssiW-1:0];
        ratpp_pkg::CFG_MID_FLOOR:   cfg_q.mid_floor  <= cfg_wdata_i[ratpp_pkg::RssiW-1:0];
        ratpp_pkg::CFG_WEAK_LIMIT:  cfg_q.weak_limit <= cfg_wdata_i[ratpp_pkg::RssiW-1:0];
        ratpp_pkg::CFG_LATENCY_LIM: cfg_q.latency_limit <= cfg_wdata_i;
        ratpp_pkg::CFG_PING_FAIL:
          cfg_q.ping_fail_limit <= cfg_wdata_i[ratpp_pkg::LimitW-1:0];
        ratpp_pkg::CFG_DISCONNECT:
          cfg_q.disconnect_limit <= cfg_wdata_i[ratpp_pkg::LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action         <= action_i;
      item_q.link_mode      <= ratpp_pkg::link_mode_e'(link_mode_i);
      item_q.rssi           <= rssi_dbm_i;
      item_q.ping_ok        <= ping_ok_i;
      item_q.latency        <= ping_latency_ms_i;
      item_q.scan_not_ready <= scan_not_ready_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  ratpp_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .prime_i(item_q.action),
    .push_i (!item_q.action && item_q.link_mode == ratpp_pkg::LINK_STA_UP),
    .rssi_i (item_q.rssi),
    .sum_o  (sum)
  );

  ratpp_policy #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_policy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .sum_i   (sum),
    .result_o(res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign power_write_o  = res_q.power_write;
  assign power_code_o   = res_q.power_code;
  assign restart_link_o = res_q.restart_link;
  assign request_scan_o = res_q.request_scan;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item did not reach the result register");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  a_code_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !power_write_o |-> power_code_o == ratpp_pkg::PWR_8P5)
    else $error("power code set without a power write");

endmodule

`default_nettype wire
